/* design/cfc_pkg.sv */
// cfc_pkg: types and constants shared by the frequency calibrator modules
// controller state, command and status structs, divider constants, sizes
// no dependencies
`timescale 1ns / 1ps

package cfc_pkg;

    // measuring windows per run and the width of the window index
    localparam int unsigned C_NUM_WINDOWS = 5;
    localparam int unsigned C_WIN_IDX_W   = 3;

    // reference rate and derived window and gap lengths
    localparam int unsigned C_CFG_W       = 32;
    localparam int unsigned C_CNT_W       = 64;
    localparam int unsigned C_WIN_LEN_W   = 26;
    localparam int unsigned C_GAP_LEN_W   = 23;

    // divide by 100: multiply by reciprocal, keep the bits above the shift
    localparam logic [30:0] C_DIV100_MAGIC = 31'd1374389535;
    localparam int unsigned C_DIV100_SHIFT = 37;
    localparam int unsigned C_WIN_PROD_W   = C_CFG_W + 31;

    // divide by 10 the same way
    localparam logic [31:0] C_DIV10_MAGIC  = 32'hCCCCCCCD;
    localparam int unsigned C_DIV10_SHIFT  = 35;
    localparam int unsigned C_GAP_PROD_W   = C_WIN_LEN_W + 32;

    // median search: repeated minimum passes over a ring of registers
    localparam int unsigned C_SORT_POS_W   = 3;
    localparam int unsigned C_SORT_PASS_W  = 2;

    // input transaction kinds and result status codes
    localparam logic C_KIND_START  = 1'b0;
    localparam logic C_KIND_SAMPLE = 1'b1;
    localparam logic C_STATUS_DONE = 1'b0;
    localparam logic C_STATUS_ERR  = 1'b1;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_OPEN   = 8'b0000_0010,
        S_WINDOW = 8'b0000_0100,
        S_GAP    = 8'b0000_1000,
        S_MUL1   = 8'b0001_0000,
        S_MUL2   = 8'b0010_0000,
        S_SORT   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic start_run;
        logic mark_all;
        logic capture;
        logic mul1;
        logic push;
        logic sort_step;
        logic load_err;
        logic load_done;
    } t_cmd;

    typedef struct packed {
        logic cfg_busy;
        logic cfg_zero;
        logic win_done;
        logic gap_done;
        logic last_window;
        logic sort_done;
    } t_sts;

endpackage

/* design/clock_frequency_calibrator_core.sv */
// clock_frequency_calibrator_core: measures an unknown counter against a reference
// counter, median of five windows; top level with the result register
// depends on cfc_pkg, cfc_ctrl, cfc_datapath
//
// usage
//   input channel: i_in_valid / o_in_stall carry one transaction of i_kind,
//   i_ref_count and i_tsc_count. a start transaction (kind 0) begins a run, or
//   answers at once with status 1 and frequency 0 when the reference rate is 0.
//   sample transactions (kind 1) carry both counters taken at the same moment.
//   output channel: o_out_valid / i_out_stall carry o_status and o_freq_hz.
//   configuration: i_cfg_we writes i_cfg_wdata into the reference rate; the
//   input is stalled after a write while the window and gap lengths are
//   recomputed through two reciprocal multipliers.
// timing
//   samples are taken one per cycle while the input is not stalled; a sample
//   that closes a window stalls the input during the times-100 step. after the
//   fifth window the median search runs fourteen steps over a five-entry ring.
//   a start that fails appears on the output in the cycle after it is taken.
// reset and stall
//   reset clears the rate to 0 and leaves the block idle with no result.
//   while a result is held by i_out_stall, samples still flow; start
//   transactions and a finished run wait until the output register frees up
`timescale 1ns / 1ps

module clock_frequency_calibrator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [63:0] i_ref_count,
    input  logic [63:0] i_tsc_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_status,
    output logic [63:0] o_freq_hz,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    cfc_pkg::t_cmd               w_cmd;
    cfc_pkg::t_sts               w_sts;
    logic [cfc_pkg::C_CNT_W-1:0] w_median;
    logic                        w_out_full;

    logic                        r_out_valid;
    logic                        n_out_valid;
    logic                        r_status;
    logic [cfc_pkg::C_CNT_W-1:0] r_freq_hz;

    // output slot is busy only if a held result is not taken this cycle
    assign w_out_full = r_out_valid && i_out_stall;

    cfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_out_full (w_out_full),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    cfc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_ref_count (i_ref_count),
        .i_tsc_count (i_tsc_count),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_median    (w_median)
    );

    // result register: loaded by an error start or a finished run
    always_comb begin
        n_out_valid = w_out_full;
        if (w_cmd.load_err || w_cmd.load_done) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.load_err) begin
            r_status  <= cfc_pkg::C_STATUS_ERR;
            r_freq_hz <= '0;
        end else if (w_cmd.load_done) begin
            r_status  <= cfc_pkg::C_STATUS_DONE;
            r_freq_hz <= w_median;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_freq_hz   = r_freq_hz;

    // a start with no reference rate answers with an error on the next cycle
    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_kind == cfc_pkg::C_KIND_START) && w_sts.cfg_zero)
        |=> (o_out_valid && (o_status == cfc_pkg::C_STATUS_ERR) && (o_freq_hz == '0)))
        else $error("error result missing after start with zero reference rate");

    // a new result never overwrites one that is still held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.load_err || w_cmd.load_done) |-> !w_out_full)
        else $error("result register overwritten while stalled");

    // thresholds are being recomputed after a rate write, so the input holds off
    a_cfg_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_in_stall)
        else $error("input accepted while thresholds settle");

endmodule

/* design/cfc_ctrl.sv */
// cfc_ctrl: calibration sequencer, one-hot state machine
// drives datapath commands and the input stall, reads datapath status
// depends on cfc_pkg
`timescale 1ns / 1ps

module cfc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_kind,
    input  logic          i_out_full,
    input  cfc_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output cfc_pkg::t_cmd o_cmd
);

    cfc_pkg::t_state r_state;
    cfc_pkg::t_state n_state;
    logic            w_take;
    logic            w_acc;

    // states that take transactions
    assign w_take = (r_state == cfc_pkg::S_IDLE) || (r_state == cfc_pkg::S_OPEN) ||
                    (r_state == cfc_pkg::S_WINDOW) || (r_state == cfc_pkg::S_GAP);

    // a start may produce a result, so it waits for a free output slot
    assign o_in_stall = i_sts.cfg_busy || !w_take ||
                        ((i_kind == cfc_pkg::C_KIND_START) && i_out_full);
    assign w_acc = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        if (w_acc && (i_kind == cfc_pkg::C_KIND_START)) begin
            o_cmd.start_run = 1'b1;
            if (i_sts.cfg_zero) begin
                o_cmd.load_err = 1'b1;
                n_state        = cfc_pkg::S_IDLE;
            end else begin
                n_state = cfc_pkg::S_OPEN;
            end
        end else begin
            case (r_state)
                cfc_pkg::S_IDLE: begin
                    n_state = cfc_pkg::S_IDLE;
                end
                cfc_pkg::S_OPEN: begin
                    if (w_acc) begin
                        o_cmd.mark_all = 1'b1;
                        n_state        = cfc_pkg::S_WINDOW;
                    end
                end
                cfc_pkg::S_WINDOW: begin
                    if (w_acc && i_sts.win_done) begin
                        o_cmd.capture = 1'b1;
                        n_state       = cfc_pkg::S_MUL1;
                    end
                end
                cfc_pkg::S_GAP: begin
                    if (w_acc && i_sts.gap_done) begin
                        o_cmd.mark_all = 1'b1;
                        n_state        = cfc_pkg::S_WINDOW;
                    end
                end
                cfc_pkg::S_MUL1: begin
                    o_cmd.mul1 = 1'b1;
                    n_state    = cfc_pkg::S_MUL2;
                end
                cfc_pkg::S_MUL2: begin
                    o_cmd.push = 1'b1;
                    n_state    = i_sts.last_window ? cfc_pkg::S_SORT : cfc_pkg::S_GAP;
                end
                cfc_pkg::S_SORT: begin
                    o_cmd.sort_step = 1'b1;
                    if (i_sts.sort_done) begin
                        n_state = cfc_pkg::S_DONE;
                    end
                end
                cfc_pkg::S_DONE: begin
                    if (!i_out_full) begin
                        o_cmd.load_done = 1'b1;
                        n_state         = cfc_pkg::S_IDLE;
                    end
                end
                default: begin
                    n_state = cfc_pkg::S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* design/cfc_datapath.sv */
// cfc_datapath: reference rate register, window thresholds, marks,
// window estimates and the median search ring
// depends on cfc_pkg
`timescale 1ns / 1ps

module cfc_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cfc_pkg::C_CFG_W-1:0]   i_cfg_wdata,
    input  logic [cfc_pkg::C_CNT_W-1:0]   i_ref_count,
    input  logic [cfc_pkg::C_CNT_W-1:0]   i_tsc_count,
    input  cfc_pkg::t_cmd                 i_cmd,
    output cfc_pkg::t_sts                 o_sts,
    output logic [cfc_pkg::C_CNT_W-1:0]   o_median
);

    logic [cfc_pkg::C_CFG_W-1:0]      r_cfg;
    logic [1:0]                       r_settle;
    logic [cfc_pkg::C_WIN_LEN_W-1:0]  r_win_len;
    logic [cfc_pkg::C_GAP_LEN_W-1:0]  r_gap_len;
    logic [cfc_pkg::C_WIN_PROD_W-1:0] w_win_prod;
    logic [cfc_pkg::C_GAP_PROD_W-1:0] w_gap_prod;

    logic [cfc_pkg::C_CNT_W-1:0]      r_ref_mark;
    logic [cfc_pkg::C_CNT_W-1:0]      r_tsc_mark;
    logic [cfc_pkg::C_CNT_W-1:0]      r_delta;
    logic [cfc_pkg::C_CNT_W-1:0]      r_prod;
    logic [cfc_pkg::C_CNT_W-1:0]      w_ref_diff;
    logic [cfc_pkg::C_CNT_W-1:0]      w_scaled;
    logic [cfc_pkg::C_WIN_IDX_W-1:0]  r_win_idx;

    logic [cfc_pkg::C_CNT_W-1:0]      r_meas [cfc_pkg::C_NUM_WINDOWS];
    logic [cfc_pkg::C_SORT_POS_W-1:0] r_sort_pos;
    logic [cfc_pkg::C_SORT_PASS_W-1:0] r_sort_pass;
    logic                             w_drop;
    logic                             w_swap;

    // thresholds follow the rate register: r_win_len is registered from r_cfg, r_gap_len from r_win_len
    assign w_win_prod = cfc_pkg::C_WIN_PROD_W'(r_cfg) *
                        cfc_pkg::C_WIN_PROD_W'(cfc_pkg::C_DIV100_MAGIC);
    assign w_gap_prod = cfc_pkg::C_GAP_PROD_W'(r_win_len) *
                        cfc_pkg::C_GAP_PROD_W'(cfc_pkg::C_DIV10_MAGIC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= '0;
            r_settle  <= '0;
            r_win_len <= '0;
            r_gap_len <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg    <= i_cfg_wdata;
                r_settle <= 2'd2;
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
            r_win_len <= w_win_prod[cfc_pkg::C_DIV100_SHIFT +: cfc_pkg::C_WIN_LEN_W];
            r_gap_len <= w_gap_prod[cfc_pkg::C_DIV10_SHIFT +: cfc_pkg::C_GAP_LEN_W];
        end
    end

    // modulo 2^64 reference delta, compared against both lengths
    assign w_ref_diff = i_ref_count - r_ref_mark;

    // times 100 as shifts and adds: r_prod holds 96 times the delta, plus 4 times here
    assign w_scaled = r_prod + (r_delta << 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_mark <= '0;
            r_tsc_mark <= '0;
            r_win_idx  <= '0;
        end else begin
            if (i_cmd.mark_all) begin
                r_ref_mark <= i_ref_count;
                r_tsc_mark <= i_tsc_count;
            end else if (i_cmd.capture) begin
                r_ref_mark <= i_ref_count;
            end
            if (i_cmd.start_run) begin
                r_win_idx <= '0;
            end else if (i_cmd.push) begin
                r_win_idx <= r_win_idx + cfc_pkg::C_WIN_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_delta <= i_tsc_count - r_tsc_mark;
        end
        if (i_cmd.mul1) begin
            r_prod <= (r_delta << 6) + (r_delta << 5);
        end
    end

    // median: repeated minimum passes; entry zero collects the minimum and
    // is then retired by overwriting it with the top value
    assign w_drop = (r_sort_pos == cfc_pkg::C_SORT_POS_W'(cfc_pkg::C_NUM_WINDOWS - 1));
    assign w_swap = r_meas[0] > r_meas[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_pos  <= '0;
            r_sort_pass <= '0;
        end else if (i_cmd.sort_step) begin
            if (w_drop) begin
                r_sort_pos  <= '0;
                r_sort_pass <= r_sort_pass + cfc_pkg::C_SORT_PASS_W'(1);
            end else begin
                r_sort_pos <= r_sort_pos + cfc_pkg::C_SORT_POS_W'(1);
            end
        end else begin
            r_sort_pos  <= '0;
            r_sort_pass <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            for (int i = 0; i < cfc_pkg::C_NUM_WINDOWS - 1; i++) begin
                r_meas[i] <= r_meas[i + 1];
            end
            r_meas[cfc_pkg::C_NUM_WINDOWS - 1] <= w_scaled;
        end else if (i_cmd.sort_step) begin
            if (w_drop) begin
                r_meas[0] <= '1;
            end else begin
                r_meas[0] <= w_swap ? r_meas[1] : r_meas[0];
                for (int i = 1; i < cfc_pkg::C_NUM_WINDOWS - 1; i++) begin
                    r_meas[i] <= r_meas[i + 1];
                end
                r_meas[cfc_pkg::C_NUM_WINDOWS - 1] <= w_swap ? r_meas[0] : r_meas[1];
            end
        end
    end

    assign o_median = r_meas[0];

    always_comb begin
        o_sts.cfg_busy    = (r_settle != 2'd0);
        o_sts.cfg_zero    = (r_cfg == '0);
        o_sts.win_done    = (w_ref_diff >= cfc_pkg::C_CNT_W'(r_win_len));
        o_sts.gap_done    = (w_ref_diff >= cfc_pkg::C_CNT_W'(r_gap_len));
        o_sts.last_window = (r_win_idx ==
                             cfc_pkg::C_WIN_IDX_W'(cfc_pkg::C_NUM_WINDOWS - 1));
        o_sts.sort_done   = (r_sort_pass ==
                             cfc_pkg::C_SORT_PASS_W'(cfc_pkg::C_NUM_WINDOWS / 2)) &&
                            (r_sort_pos ==
                             cfc_pkg::C_SORT_POS_W'(cfc_pkg::C_NUM_WINDOWS - 2));
    end

endmodule
